### rtl/core/vump_pkg.sv
package vump_pkg;

  // Geometry of the meter.
  localparam int BANDS        = 7;
  localparam int SEGMENT_LEDS = 10;
  localparam int FULL_SCALE   = 200;
  localparam int LEVEL_SCALE  = 10;
  localparam int HUE_TOP      = 224;
  localparam int BRIGHT_MIN   = 16;

  // Peak memory layout: one entry per channel and band.
  localparam int ENTRIES  = 2 * BANDS;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int PEAK_W   = $clog2(SEGMENT_LEDS + 1);
  localparam int STAMP_W  = 32;

  // Field widths of the word ports.
  localparam int BAND_W   = 3;
  localparam int LEVEL_W  = 8;
  localparam int HUE_W    = 8;
  localparam int BRIGHT_W = 8;

  // Bar arithmetic: 10*level and weight*slow both fit in MUL_W bits.
  localparam int MUL_W    = 12;
  localparam int D_W      = MUL_W + 1;

  // Brightness: fast*239/255, the division done as a reciprocal multiply.
  localparam int BRIGHT_NUM   = 239;
  localparam int T_W          = 16;
  localparam int RECIP_W      = 17;
  localparam int BRIGHT_RECIP = 32897;
  localparam int BRIGHT_SHIFT = 23;
  localparam int PROD_W       = T_W + RECIP_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WEIGHT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] HOLD_RST     = 16'd150;
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RST = 16'd150;
  localparam logic [WEIGHT_W-1:0]   WEIGHT_RST   = 4'd3;

  // Opcodes of the input word.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_S_MATH,
    ST_S_UPD,
    ST_T_CHK,
    ST_T_WALK
  } state_t;

  typedef struct packed {
    logic [PEAK_W-1:0]  peak;
    logic [STAMP_W-1:0] stamp;
  } peak_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    peak_entry_t       wr_data;
  } mem_req_t;

  // Smallest scaled level that lights k LEDs.
  function automatic logic [D_W-1:0] bar_thr(input int k);
    int q;
    q = (k * FULL_SCALE + SEGMENT_LEDS - 1) / SEGMENT_LEDS;
    return D_W'(LEVEL_SCALE * q);
  endfunction

  // Band hue: 224 - floor(224*band/6).
  function automatic logic [HUE_W-1:0] band_hue(input logic [BAND_W-1:0] band);
    logic [HUE_W-1:0] h;
    unique case (band)
      3'd0:    h = 8'd224;
      3'd1:    h = 8'd187;
      3'd2:    h = 8'd150;
      3'd3:    h = 8'd112;
      3'd4:    h = 8'd75;
      3'd5:    h = 8'd38;
      3'd6:    h = 8'd0;
      default: h = 8'd0;
    endcase
    return h;
  endfunction

endpackage

### rtl/core/vump_peak_mem.sv
module vump_peak_mem
  import vump_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mem_req_t    req,
  output peak_entry_t rd_data
);

  peak_entry_t              entry_mem_r [ENTRIES];
  logic [ENTRIES-1:0]       valid_r;
  peak_entry_t              rd_data_r;
  logic                     rd_vld_r;

  // Storage array with a registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      entry_mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= entry_mem_r[req.rd_addr];
    end
  end

  // Per-entry valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/core/vu_meter_peak_hold.sv
// VU meter bar graph with peak hold. A sample word (opcode 0) turns level minus
// a weighted share of slow_level into a bar of 0 to 10 LEDs, raises the held
// peak of its channel and band when the bar is longer, and returns one result
// word with bar, peak, hue and brightness; a sample for a band of 7 or more is
// dropped without a result. A tick word (opcode 1) gives no result; once the
// decay interval has passed it lowers by one every peak held longer than
// hold_ms. Held peaks and their time stamps live in a 14-entry memory with a
// registered read. A sample passes through ST_S_MATH and ST_S_UPD before the
// next acceptance and waits in ST_S_UPD while a previous result word is still
// stalled. A tick passes ST_T_CHK and, when decay is due, ST_T_WALK, where the
// single read port walks all 14 memory entries. The user must write registers
// through cfg_wr_en, cfg_index and cfg_wdata only while the block is idle; the
// block does not enforce this. After reset all peaks read as zero at once.
module vu_meter_peak_hold
  import vump_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic                  in_channel,
  input  logic [BAND_W-1:0]     in_band,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic [LEVEL_W-1:0]    in_slow_level,
  input  logic [LEVEL_W-1:0]    in_fast_level,
  input  logic [STAMP_W-1:0]    in_now_ms,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_channel,
  output logic [BAND_W-1:0]     out_band,
  output logic [PEAK_W-1:0]     out_bar_length,
  output logic [PEAK_W-1:0]     out_peak_length,
  output logic                  out_peak_shown,
  output logic [HUE_W-1:0]      out_hue,
  output logic [BRIGHT_W-1:0]   out_brightness
);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] hold_r;
  logic [CFG_DATA_W-1:0] interval_r;
  logic [WEIGHT_W-1:0]   weight_r;

  // Latched input word.
  logic                  chan_r;
  logic [BAND_W-1:0]     band_r;
  logic [LEVEL_W-1:0]    level_r;
  logic [LEVEL_W-1:0]    slow_r;
  logic [LEVEL_W-1:0]    fast_r;
  logic [STAMP_W-1:0]    now_r;

  // Arithmetic stage.
  logic signed [D_W-1:0] d_r;
  logic [T_W-1:0]        t_r;

  logic [STAMP_W-1:0]    last_decay_r;

  // Decay walk.
  logic [CNT_W-1:0]      walk_cnt_r, walk_cnt_nxt;
  logic                  walk_wr_vld_r, walk_wr_vld_nxt;
  logic [IDX_W-1:0]      walk_wr_idx_r, walk_wr_idx_nxt;

  // Result word register.
  logic                  out_valid_r;
  logic                  out_chan_r;
  logic [BAND_W-1:0]     out_band_r;
  logic [PEAK_W-1:0]     out_bar_r;
  logic [PEAK_W-1:0]     out_peak_r;
  logic [HUE_W-1:0]      out_hue_r;
  logic [BRIGHT_W-1:0]   out_bright_r;

  mem_req_t              mem_req;
  peak_entry_t           mem_rd;

  logic                  in_acc;
  logic                  out_free;
  logic                  band_ok;
  logic [IDX_W-1:0]      in_idx;
  logic                  decay_due;
  logic                  walk_dec;
  logic                  walk_done;
  logic                  load_in;
  logic                  load_out;
  logic                  start_walk;

  logic [MUL_W-1:0]      lvl_scaled;
  logic [MUL_W-1:0]      slow_scaled;
  logic signed [D_W-1:0] d_nxt;
  logic [T_W-1:0]        t_nxt;
  logic [PEAK_W-1:0]     bar;
  logic                  bar_gt;
  logic [PEAK_W-1:0]     peak_new;
  logic [PROD_W-1:0]     bright_prod;
  logic [BRIGHT_W-1:0]   bright;

  vump_peak_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  // Handshake and common conditions.
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign band_ok   = (32'(in_band) < BANDS);
  assign in_idx    = in_channel ? IDX_W'(32'(in_band) + BANDS) : IDX_W'(in_band);
  assign decay_due = (now_r - last_decay_r) > {{(STAMP_W-CFG_DATA_W){1'b0}}, interval_r};
  assign walk_done = (walk_cnt_r == CNT_W'(ENTRIES));
  assign walk_dec  = walk_wr_vld_r && (mem_rd.peak != '0) &&
                     ((now_r - mem_rd.stamp) > {{(STAMP_W-CFG_DATA_W){1'b0}}, hold_r});

  // Scaled level difference and brightness numerator.
  always_comb begin
    lvl_scaled  = MUL_W'(level_r) * MUL_W'(LEVEL_SCALE);
    slow_scaled = MUL_W'(slow_r) * MUL_W'(weight_r);
    d_nxt       = $signed({1'b0, lvl_scaled}) - $signed({1'b0, slow_scaled});
    t_nxt       = T_W'(fast_r) * T_W'(BRIGHT_NUM);
  end

  // Bar length: count the thresholds the scaled difference reaches.
  always_comb begin
    bar = '0;
    for (int k = 1; k <= SEGMENT_LEDS; k++) begin
      if (d_r >= $signed(bar_thr(k))) begin
        bar = bar + 1'b1;
      end
    end
    bar_gt   = (bar > mem_rd.peak);
    peak_new = bar_gt ? bar : mem_rd.peak;
  end

  // Brightness: floor(t/255) by reciprocal multiply, then offset.
  always_comb begin
    bright_prod = PROD_W'(t_r) * PROD_W'(BRIGHT_RECIP);
    bright      = BRIGHT_W'(bright_prod >> BRIGHT_SHIFT) + BRIGHT_W'(BRIGHT_MIN);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_TICK) begin
            state_nxt = ST_T_CHK;
          end else if (band_ok) begin
            state_nxt = ST_S_MATH;
          end
        end
      end
      ST_S_MATH: state_nxt = ST_S_UPD;
      ST_S_UPD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_T_CHK:  state_nxt = decay_due ? ST_T_WALK : ST_IDLE;
      ST_T_WALK: begin
        if (walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and memory requests.
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    load_in         = 1'b0;
    load_out        = 1'b0;
    start_walk      = 1'b0;
    walk_cnt_nxt    = walk_cnt_r;
    walk_wr_vld_nxt = 1'b0;
    walk_wr_idx_nxt = walk_wr_idx_r;
    mem_req         = '0;
    unique case (state_r)
      ST_IDLE: begin
        load_in         = in_acc;
        mem_req.rd_en   = in_acc && (in_opcode == OP_SAMPLE) && band_ok;
        mem_req.rd_addr = in_idx;
      end
      ST_S_MATH: begin
      end
      ST_S_UPD: begin
        load_out                = out_free;
        mem_req.wr_en           = out_free && bar_gt;
        mem_req.wr_addr         = IDX_W'(chan_r ? 32'(band_r) + BANDS : 32'(band_r));
        mem_req.wr_data.peak    = bar;
        mem_req.wr_data.stamp   = now_r;
      end
      ST_T_CHK: begin
        start_walk   = decay_due;
        walk_cnt_nxt = '0;
      end
      ST_T_WALK: begin
        // Read one entry per cycle, write back the previous one when its peak decays.
        if (!walk_done) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = walk_cnt_r[IDX_W-1:0];
          walk_wr_vld_nxt = 1'b1;
          walk_wr_idx_nxt = walk_cnt_r[IDX_W-1:0];
          walk_cnt_nxt    = walk_cnt_r + 1'b1;
        end
        mem_req.wr_en         = walk_dec;
        mem_req.wr_addr       = walk_wr_idx_r;
        mem_req.wr_data.peak  = mem_rd.peak - 1'b1;
        mem_req.wr_data.stamp = mem_rd.stamp;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      hold_r        <= HOLD_RST;
      interval_r    <= INTERVAL_RST;
      weight_r      <= WEIGHT_RST;
      last_decay_r  <= '0;
      walk_cnt_r    <= '0;
      walk_wr_vld_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      walk_cnt_r    <= walk_cnt_nxt;
      walk_wr_vld_r <= walk_wr_vld_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_HOLD:     hold_r     <= cfg_wdata;
          CFG_INTERVAL: interval_r <= cfg_wdata;
          CFG_WEIGHT:   weight_r   <= cfg_wdata[WEIGHT_W-1:0];
          default: begin
          end
        endcase
      end
      if (start_walk) begin
        last_decay_r <= now_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    walk_wr_idx_r <= walk_wr_idx_nxt;
    if (load_in) begin
      chan_r  <= in_channel;
      band_r  <= in_band;
      level_r <= in_level;
      slow_r  <= in_slow_level;
      fast_r  <= in_fast_level;
      now_r   <= in_now_ms;
    end
    if (state_r == ST_S_MATH) begin
      d_r <= d_nxt;
      t_r <= t_nxt;
    end
    if (load_out) begin
      out_chan_r   <= chan_r;
      out_band_r   <= band_r;
      out_bar_r    <= bar;
      out_peak_r   <= peak_new;
      out_hue_r    <= band_hue(band_r);
      out_bright_r <= bright;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_chan_r;
  assign out_band        = out_band_r;
  assign out_bar_length  = out_bar_r;
  assign out_peak_length = out_peak_r;
  assign out_peak_shown  = (out_peak_r > PEAK_W'(1));
  assign out_hue         = out_hue_r;
  assign out_brightness  = out_bright_r;

endmodule
